### rtl/core/rse_pkg.sv
// ----------------------------------------------------------------------------
// rse_pkg
// Shared constants for the RPN stack evaluator: item kinds, operator bytes,
// status codes and stream field widths.
// ----------------------------------------------------------------------------
package rse_pkg;

  localparam int unsigned StackDepthDef = 16;

  localparam int unsigned DataW  = 32;
  localparam int unsigned OpW    = 8;
  localparam int unsigned FuncW  = 2;
  localparam int unsigned StatW  = 3;
  localparam int unsigned InTdataW  = 40;   // op_char + const_value, byte padded
  localparam int unsigned OutTdataW = 40;   // result + status, byte padded

  localparam logic [FuncW-1:0] FUNC_PUSH  = 2'd0;
  localparam logic [FuncW-1:0] FUNC_BIN   = 2'd1;
  localparam logic [FuncW-1:0] FUNC_UNARY = 2'd2;

  localparam logic [OpW-1:0] OP_ADD = 8'h2B;
  localparam logic [OpW-1:0] OP_SUB = 8'h2D;
  localparam logic [OpW-1:0] OP_MUL = 8'h2A;
  localparam logic [OpW-1:0] OP_DIV = 8'h2F;

  localparam logic [StatW-1:0] ST_OK    = 3'd0;
  localparam logic [StatW-1:0] ST_UNDER = 3'd1;
  localparam logic [StatW-1:0] ST_OVER  = 3'd2;
  localparam logic [StatW-1:0] ST_DIVZ  = 3'd3;
  localparam logic [StatW-1:0] ST_DEPTH = 3'd4;

endpackage

### rtl/core/rpn_stack_evaluator_unit.sv
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_unit
// Postfix expression evaluator on a bounded stack of 32-bit signed integers.
// ----------------------------------------------------------------------------
// The top of stack lives in a register and the entries below it in a RAM with
// a registered read. A push and a unary operator or an unknown kind pass
// through S_DECODE and S_FIN; a binary '+', '-', '*' or unknown operator adds
// S_EXEC (one RAM read for the first operand), and a '/' adds S_DIV and S_DFIN
// on the restoring divider that retires one quotient bit per cycle; a '/' by
// zero skips the divider, and an item that underflows or overflows goes from
// S_DECODE to S_FIN. The input is not ready while an item is in work. On the
// item with tlast set, one result transfer carries the bottom entry (zero on a
// fault) and the sticky status; the stack and status then clear. A finished
// result waits in the output register while the next item is taken; a later
// tlast item that finds it still waiting holds in S_FIN, input not ready,
// until that result transfers.
module rpn_stack_evaluator_unit #(
  parameter int unsigned STACK_DEPTH = rse_pkg::StackDepthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [rse_pkg::InTdataW-1:0]   s_axis_tdata,   // op_char, const_value
  input  logic [rse_pkg::FuncW-1:0]      s_axis_tuser,   // func
  input  logic                           s_axis_tlast,   // end_of_expr
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [rse_pkg::OutTdataW-1:0]  m_axis_tdata    // result, status
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned DW = rse_pkg::DataW;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_EXEC   = 6'b000100,
    S_DIV    = 6'b001000,
    S_DFIN   = 6'b010000,
    S_FIN    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0]               count_q, count_d;
  logic [rse_pkg::StatW-1:0]   err_q, err_d;
  logic                        out_valid_q, out_valid_d;

  logic [DW-1:0]               tos_q, tos_d;
  logic [rse_pkg::FuncW-1:0]   func_q;
  logic [rse_pkg::OpW-1:0]     op_q;
  logic [DW-1:0]               cval_q;
  logic                        last_q;
  logic [DW-1:0]               out_res_q, out_res_d;
  logic [rse_pkg::StatW-1:0]   out_st_q, out_st_d;

  logic [DW-1:0]               rem_q, rem_d;
  logic [DW-1:0]               quo_q, quo_d;
  logic [DW-1:0]               den_q, den_d;
  logic [4:0]                  dcnt_q, dcnt_d;
  logic                        dneg_q, dneg_d;

  logic                        in_xfer;
  logic                        ram_we;
  logic [CW-1:0]               count_m1, count_m2;
  logic [DW-1:0]               opnd_a, opnd_b, mul_lo;
  logic [DW:0]                 trial;
  logic [rse_pkg::StatW-1:0]   fin_st;

  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(rse_pkg::OutTdataW - DW - rse_pkg::StatW){1'b0}},
                          out_st_q, out_res_q};

  assign count_m1 = count_q - CW'(1);
  assign count_m2 = count_q - CW'(2);
  assign opnd_b   = tos_q;
  assign mul_lo   = DW'(opnd_a * opnd_b);
  assign trial    = {rem_q, quo_q[DW-1]} - {1'b0, den_q};
  assign ram_we   = (state_q == S_DECODE) && (func_q == rse_pkg::FUNC_PUSH) &&
                    (count_q < CW'(STACK_DEPTH)) && (count_q != '0);

  rse_ram #(
    .WIDTH (DW),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_m1[AW-1:0]),
    .wdata_i (tos_q),
    .raddr_i (count_m2[AW-1:0]),
    .rdata_o (opnd_a)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    err_d       = err_q;
    tos_d       = tos_q;
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    out_st_d    = out_st_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    den_d       = den_q;
    dcnt_d      = dcnt_q;
    dneg_d      = dneg_q;
    fin_st      = ((err_q == rse_pkg::ST_OK) && (count_q != CW'(1))) ?
                  rse_pkg::ST_DEPTH : err_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_FIN;
        case (func_q)
          rse_pkg::FUNC_PUSH: begin
            if (count_q >= CW'(STACK_DEPTH)) begin
              if (err_q == rse_pkg::ST_OK) err_d = rse_pkg::ST_OVER;
            end else begin
              tos_d   = cval_q;
              count_d = count_q + CW'(1);
            end
          end
          rse_pkg::FUNC_BIN: begin
            if (count_q < CW'(2)) begin
              if (err_q == rse_pkg::ST_OK) err_d = rse_pkg::ST_UNDER;
            end else begin
              state_d = S_EXEC;
            end
          end
          rse_pkg::FUNC_UNARY: begin
            if (count_q == '0) begin
              if (err_q == rse_pkg::ST_OK) err_d = rse_pkg::ST_UNDER;
            end else begin
              tos_d = (op_q == rse_pkg::OP_SUB) ? (DW'(0) - tos_q) : '0;
            end
          end
          default: ;
        endcase
      end
      S_EXEC: begin
        count_d = count_m1;
        state_d = S_FIN;
        case (op_q)
          rse_pkg::OP_ADD: tos_d = opnd_a + opnd_b;
          rse_pkg::OP_SUB: tos_d = opnd_a - opnd_b;
          rse_pkg::OP_MUL: tos_d = mul_lo;
          rse_pkg::OP_DIV: begin
            if (opnd_b == '0) begin
              tos_d = '0;
              if (err_q == rse_pkg::ST_OK) err_d = rse_pkg::ST_DIVZ;
            end else begin
              quo_d   = opnd_a[DW-1] ? (DW'(0) - opnd_a) : opnd_a;
              den_d   = opnd_b[DW-1] ? (DW'(0) - opnd_b) : opnd_b;
              rem_d   = '0;
              dcnt_d  = '0;
              dneg_d  = opnd_a[DW-1] ^ opnd_b[DW-1];
              state_d = S_DIV;
            end
          end
          default: tos_d = '0;
        endcase
      end
      S_DIV: begin
        if (!trial[DW]) begin
          rem_d = trial[DW-1:0];
          quo_d = {quo_q[DW-2:0], 1'b1};
        end else begin
          rem_d = {rem_q[DW-2:0], quo_q[DW-1]};
          quo_d = {quo_q[DW-2:0], 1'b0};
        end
        dcnt_d = dcnt_q + 5'd1;
        if (dcnt_q == 5'd31) begin
          state_d = S_DFIN;
        end
      end
      S_DFIN: begin
        tos_d   = dneg_q ? (DW'(0) - quo_q) : quo_q;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!last_q) begin
          state_d = S_IDLE;
        end else if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_st_d    = fin_st;
          out_res_d   = (fin_st == rse_pkg::ST_OK) ? tos_q : '0;
          count_d     = '0;
          err_d       = rse_pkg::ST_OK;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      err_q       <= rse_pkg::ST_OK;
      out_valid_q <= 1'b0;
      dcnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
      dcnt_q      <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      func_q <= s_axis_tuser;
      op_q   <= s_axis_tdata[rse_pkg::OpW-1:0];
      cval_q <= s_axis_tdata[rse_pkg::OpW +: DW];
      last_q <= s_axis_tlast;
    end
    tos_q     <= tos_d;
    out_res_q <= out_res_d;
    out_st_q  <= out_st_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    den_q     <= den_d;
    dneg_q    <= dneg_d;
  end

endmodule

### rtl/core/rse_ram.sv
// ----------------------------------------------------------------------------
// rse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/core/rse_checker.sv
// ----------------------------------------------------------------------------
// rse_checker
// Port-level checks for the RPN stack evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module rse_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [rse_pkg::OutTdataW-1:0]  m_axis_tdata
);

  logic in_xfer;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // busy after each transfer
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !s_axis_tready)
    else $error("input ready right after a transfer");

  // a result never shows up the cycle after a transfer
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !$rose(m_axis_tvalid))
    else $error("result too early");

  // faulted result reads zero
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[34:32] != rse_pkg::ST_OK)
      |-> (m_axis_tdata[31:0] == '0))
    else $error("nonzero result with fault status");

endmodule

bind rpn_stack_evaluator_unit rse_checker u_rse_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
